// ----- rtl/core/alu8f_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and constants for the eight-bit ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

  // Flag bit positions in a 4-bit flag nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Operation codes; other codes of the 5-bit field are no-ops
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_RLC  = 5'd8,
    OP_RRC  = 5'd9,
    OP_RL   = 5'd10,
    OP_RR   = 5'd11,
    OP_SLA  = 5'd12,
    OP_SRA  = 5'd13,
    OP_SWAP = 5'd14,
    OP_SRL  = 5'd15,
    OP_BIT  = 5'd16
  } alu_op_e;

  // Decode stage payload
  typedef struct packed {
    alu_op_e     op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  b_add;   // adder operand, inverted for subtract
    logic        c_add;   // adder carry in
    logic [3:0]  flags;
    logic [2:0]  idx;
  } dec_t;

  // Execute stage payload
  typedef struct packed {
    logic [7:0]  res;
    logic        z_from_res;  // Z comes from res == 0, else from z_alt
    logic        z_alt;
    logic        n;
    logic        h;
    logic        c;
    logic        wb;
  } exe_t;

endpackage

// ----- rtl/core/alu8f_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_exec
// Execute logic: adder, logic ops, shifts/rotates, swap and bit test.
// ----------------------------------------------------------------------------
module alu8f_exec
  import alu8f_pkg::*;
(
  input  dec_t dec_i,
  output exe_t exe_o
);

  logic [4:0] sum_lo;
  logic [8:0] sum;

  assign sum_lo = {1'b0, dec_i.a[3:0]} + {1'b0, dec_i.b_add[3:0]} + {4'b0, dec_i.c_add};
  assign sum    = {1'b0, dec_i.a} + {1'b0, dec_i.b_add} + {8'b0, dec_i.c_add};

  always_comb begin
    exe_o            = '0;
    exe_o.z_from_res = 1'b1;
    exe_o.wb         = 1'b1;
    unique case (dec_i.op)
      OP_ADD, OP_ADC: begin
        exe_o.res = sum[7:0];
        exe_o.h   = sum_lo[4];
        exe_o.c   = sum[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // carry out of a + ~b + ~cin is the inverse of the borrow
        exe_o.res = sum[7:0];
        exe_o.n   = 1'b1;
        exe_o.h   = ~sum_lo[4];
        exe_o.c   = ~sum[8];
        exe_o.wb  = (dec_i.op != OP_CP);
      end
      OP_AND: begin
        exe_o.res = dec_i.a & dec_i.b;
        exe_o.h   = 1'b1;
      end
      OP_XOR: exe_o.res = dec_i.a ^ dec_i.b;
      OP_OR:  exe_o.res = dec_i.a | dec_i.b;
      OP_RLC: begin
        exe_o.res = {dec_i.b[6:0], dec_i.b[7]};
        exe_o.c   = dec_i.b[7];
      end
      OP_RRC: begin
        exe_o.res = {dec_i.b[0], dec_i.b[7:1]};
        exe_o.c   = dec_i.b[0];
      end
      OP_RL: begin
        exe_o.res = {dec_i.b[6:0], dec_i.flags[FlagC]};
        exe_o.c   = dec_i.b[7];
      end
      OP_RR: begin
        exe_o.res = {dec_i.flags[FlagC], dec_i.b[7:1]};
        exe_o.c   = dec_i.b[0];
      end
      OP_SLA: begin
        exe_o.res = {dec_i.b[6:0], 1'b0};
        exe_o.c   = dec_i.b[7];
      end
      OP_SRA: begin
        exe_o.res = {dec_i.b[7], dec_i.b[7:1]};
        exe_o.c   = dec_i.b[0];
      end
      OP_SWAP: exe_o.res = {dec_i.b[3:0], dec_i.b[7:4]};
      OP_SRL: begin
        exe_o.res = {1'b0, dec_i.b[7:1]};
        exe_o.c   = dec_i.b[0];
      end
      OP_BIT: begin
        exe_o.res        = dec_i.b;
        exe_o.z_from_res = 1'b0;
        exe_o.z_alt      = ~dec_i.b[dec_i.idx];
        exe_o.h          = 1'b1;
        exe_o.c          = dec_i.flags[FlagC];
        exe_o.wb         = 1'b0;
      end
      default: begin
        // unknown code: pass acc and flags, no write
        exe_o.res        = dec_i.a;
        exe_o.z_from_res = 1'b0;
        exe_o.z_alt      = dec_i.flags[FlagZ];
        exe_o.n          = dec_i.flags[FlagN];
        exe_o.h          = dec_i.flags[FlagH];
        exe_o.c          = dec_i.flags[FlagC];
        exe_o.wb         = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/eight_bit_alu_with_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Pipelined 8-bit ALU with Z/N/H/C flags: decode, execute, flag/output stage.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Payload
//  s_axis   in   s_axis_tvalid/tready   req_type, acc, operand, flags_in, bit_index
//  m_axis   out  m_axis_tvalid/tready   result, flags_out, write_back
//
//  Three register stages (decode, execute, output).
//  One transfer per cycle in and out when the sink keeps tready high.
//  Each stage holds its item while the stage ahead is full and stalled,
//  and fills bubbles, so nothing is dropped or repeated.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags
  import alu8f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] req_type, [12:5] acc, [20:13] operand, [24:21] flags_in,
  // [27:25] bit_index, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result, [11:8] flags_out, [12] write_back, [15:13] zero
  output logic [15:0] m_axis_tdata
);

  logic       v1_q, v2_q, v3_q;
  logic       v1_d, v2_d, v3_d;
  logic       rdy1, rdy2, rdy3;
  dec_t       dec_d, dec_q;
  exe_t       exe_d, exe_q;
  logic [7:0] res_d, res_q;
  logic [3:0] flg_d, flg_q;
  logic       wb_d, wb_q;

  logic [4:0] in_op;
  logic [7:0] in_acc, in_opd;
  logic [3:0] in_flags;
  logic [2:0] in_idx;

  assign in_op    = s_axis_tdata[4:0];
  assign in_acc   = s_axis_tdata[12:5];
  assign in_opd   = s_axis_tdata[20:13];
  assign in_flags = s_axis_tdata[24:21];
  assign in_idx   = s_axis_tdata[27:25];

  // Stage handshake: a stage loads when empty or when its content moves on
  assign rdy3 = ~v3_q | m_axis_tready;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;

  assign v1_d = rdy1 ? s_axis_tvalid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  // Decode: prepare adder operand and carry in
  always_comb begin
    dec_d.op    = alu_op_e'(in_op);
    dec_d.a     = in_acc;
    dec_d.b     = in_opd;
    dec_d.flags = in_flags;
    dec_d.idx   = in_idx;
    dec_d.b_add = in_opd;
    dec_d.c_add = 1'b0;
    unique case (alu_op_e'(in_op))
      OP_ADC: dec_d.c_add = in_flags[FlagC];
      OP_SUB, OP_CP: begin
        dec_d.b_add = ~in_opd;
        dec_d.c_add = 1'b1;
      end
      OP_SBC: begin
        dec_d.b_add = ~in_opd;
        dec_d.c_add = ~in_flags[FlagC];
      end
      default: ;
    endcase
  end

  alu8f_exec u_exec (
    .dec_i (dec_q),
    .exe_o (exe_d)
  );

  // Output stage: zero detect and flag assembly
  always_comb begin
    res_d        = exe_q.res;
    flg_d[FlagZ] = exe_q.z_from_res ? (exe_q.res == 8'h00) : exe_q.z_alt;
    flg_d[FlagN] = exe_q.n;
    flg_d[FlagH] = exe_q.h;
    flg_d[FlagC] = exe_q.c;
    wb_d         = exe_q.wb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      dec_q <= dec_d;
    end
    if (rdy2) begin
      exe_q <= exe_d;
    end
    if (rdy3) begin
      res_q <= res_d;
      flg_q <= flg_d;
      wb_q  <= wb_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {3'b000, wb_q, flg_q, res_q};

endmodule

// ----- test/tb_eight_bit_alu_with_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags
// Stream testbench for the eight-bit ALU with Z/N/H/C flags. Directed checks
// cover flag extremes, every operation, compare, bit test and undefined codes.
// Random phases follow, with sender gaps and sink back-pressure. A local model
// predicts each result, and a scoreboard compares the results in order.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags;
  import alu8f_pkg::*;

  localparam int unsigned PipeLatency = 3;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ShowLimit   = 10;

  typedef struct packed {
    logic [7:0] res;
    logic [3:0] flags;
    logic       wb;
  } alu_result_t;

  typedef struct {
    logic [31:0] req;
    alu_result_t res;
  } pending_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [4:0] req_type, [12:5] acc, [20:13] operand, [24:21] flags_in,
  // [27:25] bit_index, [31:28] zero
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] result, [11:8] flags_out, [12] write_back, [15:13] zero
  logic [15:0] m_axis_tdata;

  pending_result_t pending_results[$];
  int unsigned     mismatch_count = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     snd_idle_pct = 0;
  int unsigned     rcv_stall_pct = 0;

  eight_bit_alu_with_flags uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic alu_result_t predict_alu(input logic [4:0] op, input logic [7:0] a,
                                              input logic [7:0] b, input logic [3:0] f,
                                              input logic [2:0] idx);
    alu_result_t r;
    logic [8:0]  sum;
    logic [4:0]  half;
    logic        cin;
    logic        c;
    cin     = f[FlagC];
    r.res   = a;
    r.flags = '0;
    r.wb    = 1'b1;
    case (op)
      OP_ADD, OP_ADC: begin
        c    = (op == OP_ADC) ? cin : 1'b0;
        sum  = {1'b0, a} + {1'b0, b} + {8'd0, c};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
        r.res = sum[7:0];
        r.flags[FlagH] = half[4];
        r.flags[FlagC] = sum[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        c = (op == OP_SBC) ? cin : 1'b0;
        r.res = a - b - {7'd0, c};
        r.flags[FlagN] = 1'b1;
        r.flags[FlagH] = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, c}));
        r.flags[FlagC] = ({1'b0, a} < ({1'b0, b} + {8'd0, c}));
        r.wb = (op != OP_CP);
      end
      OP_AND: begin
        r.res = a & b;
        r.flags[FlagH] = 1'b1;
      end
      OP_XOR:  r.res = a ^ b;
      OP_OR:   r.res = a | b;
      OP_RLC: begin
        r.res = {b[6:0], b[7]};
        r.flags[FlagC] = b[7];
      end
      OP_RRC: begin
        r.res = {b[0], b[7:1]};
        r.flags[FlagC] = b[0];
      end
      OP_RL: begin
        r.res = {b[6:0], cin};
        r.flags[FlagC] = b[7];
      end
      OP_RR: begin
        r.res = {cin, b[7:1]};
        r.flags[FlagC] = b[0];
      end
      OP_SLA: begin
        r.res = {b[6:0], 1'b0};
        r.flags[FlagC] = b[7];
      end
      OP_SRA: begin
        r.res = {b[7], b[7:1]};
        r.flags[FlagC] = b[0];
      end
      OP_SWAP: r.res = {b[3:0], b[7:4]};
      OP_SRL: begin
        r.res = {1'b0, b[7:1]};
        r.flags[FlagC] = b[0];
      end
      default: ;
    endcase
    if (op == OP_BIT) begin
      r.res = b;
      r.flags[FlagZ] = ~b[idx];
      r.flags[FlagH] = 1'b1;
      r.flags[FlagC] = cin;
      r.wb = 1'b0;
    end else if (op > OP_BIT) begin
      // undefined codes pass acc and the flags through without a write
      r.res   = a;
      r.flags = f;
      r.wb    = 1'b0;
    end else begin
      r.flags[FlagZ] = (r.res == 8'd0);
    end
    return r;
  endfunction

  // Output check first, then capture of the new request: a request accepted
  // at this edge cannot leave before the pipeline latency.
  always @(posedge clk_i) begin
    pending_result_t exp_item;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ShowLimit)
            $display("mismatch: unexpected result %h", m_axis_tdata);
        end else begin
          exp_item = pending_results.pop_front();
          if (m_axis_tdata[7:0] !== exp_item.res.res ||
              m_axis_tdata[11:8] !== exp_item.res.flags ||
              m_axis_tdata[12] !== exp_item.res.wb ||
              m_axis_tdata[15:13] !== 3'b000) begin
            mismatch_count++;
            if (mismatch_count <= ShowLimit)
              $display("mismatch: req %h exp res=%h flags=%h wb=%b, got res=%h flags=%h wb=%b pad=%h",
                       exp_item.req, exp_item.res.res, exp_item.res.flags, exp_item.res.wb,
                       m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[12],
                       m_axis_tdata[15:13]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_item.req = s_axis_tdata;
        exp_item.res = predict_alu(s_axis_tdata[4:0], s_axis_tdata[12:5], s_axis_tdata[20:13],
                                   s_axis_tdata[24:21], s_axis_tdata[27:25]);
        pending_results.push_back(exp_item);
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_req(input logic [4:0] op, input logic [7:0] a, input logic [7:0] b,
                          input logic [3:0] f, input logic [2:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, idx, f, b, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop tvalid and let the pipeline empty out
  task automatic drain_pipe();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[6] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h01};
    if ($urandom_range(3) == 0) return corner[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  task automatic test_arith_flags();
    send_req(OP_ADD, 8'hFF, 8'h01, 4'h0, 3'd0);  // wrap to zero, H and C
    send_req(OP_ADD, 8'h0F, 8'h01, 4'hF, 3'd0);  // half carry only
    send_req(OP_ADC, 8'hFF, 8'h00, 4'h1, 3'd0);  // carry-in wraps
    send_req(OP_SUB, 8'h00, 8'h01, 4'h0, 3'd0);  // full borrow
    send_req(OP_SBC, 8'h10, 8'h0F, 4'h1, 3'd0);  // borrow-in, half borrow, zero
    send_req(OP_CP,  8'h5A, 8'h5A, 4'h0, 3'd0);  // compare equal, no write
    send_req(OP_CP,  8'h00, 8'hFF, 4'hF, 3'd0);
    drain_pipe();
  endtask

  task automatic test_logic_ops();
    send_req(OP_AND, 8'hFF, 8'h00, 4'hF, 3'd0);
    send_req(OP_AND, 8'hFF, 8'hFF, 4'h0, 3'd0);
    send_req(OP_XOR, 8'hAA, 8'hAA, 4'hF, 3'd0);
    send_req(OP_OR,  8'h00, 8'h00, 4'h0, 3'd0);
    send_req(OP_OR,  8'hA5, 8'h5A, 4'hF, 3'd0);
    drain_pipe();
  endtask

  task automatic test_shift_rotate();
    send_req(OP_RLC,  8'h00, 8'h80, 4'h0, 3'd0);
    send_req(OP_RRC,  8'hFF, 8'h01, 4'h0, 3'd0);
    send_req(OP_RL,   8'h00, 8'h80, 4'h0, 3'd0);  // shifts out to zero
    send_req(OP_RR,   8'h00, 8'h00, 4'h1, 3'd0);  // carry shifted into bit 7
    send_req(OP_SLA,  8'h00, 8'hFF, 4'h0, 3'd0);
    send_req(OP_SRA,  8'h00, 8'h81, 4'h0, 3'd0);
    send_req(OP_SWAP, 8'h00, 8'hF0, 4'hF, 3'd0);
    send_req(OP_SRL,  8'h00, 8'h01, 4'hF, 3'd0);
    drain_pipe();
  endtask

  task automatic test_bit_test();
    send_req(OP_BIT, 8'h12, 8'h80, 4'h1, 3'd7);
    send_req(OP_BIT, 8'h34, 8'hFE, 4'hE, 3'd0);
    drain_pipe();
  endtask

  task automatic test_undefined_ops();
    send_req(5'd17, 8'hC3, 8'h3C, 4'hA, 3'd5);
    send_req(5'd31, 8'h00, 8'hFF, 4'h5, 3'd2);
    drain_pipe();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned snd_pct,
                             input int unsigned rcv_pct, input bit hold_off);
    logic [4:0] op;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_off && i == count / 2) drain_pipe();
      if ($urandom_range(9) == 0) op = 5'($urandom_range(31, 17));
      else op = 5'($urandom_range(16, 0));
      send_req(op, pick_byte(), pick_byte(), 4'($urandom), 3'($urandom));
    end
    drain_pipe();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_arith_flags();
    test_logic_ops();
    test_shift_rotate();
    test_bit_test();
    test_undefined_ops();
    test_random(300, 0, 0, 1'b0);
    test_random(300, 87, 0, 1'b1);
    test_random(300, 0, 87, 1'b0);
    test_random(300, 34, 34, 1'b0);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
